[rtl/rqs_pkg.sv]
// Shared types, character codes and result kinds of the regex quantifier scanner.
package rqs_pkg;

  localparam int unsigned COUNT_BITS_DEFAULT = 32;
  localparam int unsigned LEN_BITS_DEFAULT   = 8;

  localparam int unsigned CH_W   = 8;
  localparam int unsigned KIND_W = 4;

  localparam logic [CH_W-1:0] CH_QMARK  = 8'h3F;
  localparam logic [CH_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CH_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CH_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CH_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [CH_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE   = 8'h39;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_BRACE,
    PH_DONE
  } phase_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE       = 4'd0,
    KIND_EMPTY      = 4'd1,
    KIND_OPT        = 4'd2,
    KIND_STAR       = 4'd3,
    KIND_PLUS       = 4'd4,
    KIND_N          = 4'd5,
    KIND_N_OR_MORE  = 4'd6,
    KIND_M_OR_LESS  = 4'd7,
    KIND_N_M        = 4'd8,
    KIND_UNMATCHED  = 4'd9,
    KIND_BAD_CHAR   = 4'd10,
    KIND_MANY_COMMA = 4'd11,
    KIND_BAD_RANGE  = 4'd12
  } kind_e;

  typedef struct packed {
    phase_e     phase;
    logic [1:0] comma_seen;
    logic       first_digits;
    logic       second_digits;
    logic       bad_char;
  } flags_t;

endpackage

[rtl/rqs_step.sv]
// Next-state and result logic for one character of quantifier text.
module rqs_step #(
  parameter int unsigned COUNT_BITS = rqs_pkg::COUNT_BITS_DEFAULT,
  parameter int unsigned LEN_BITS   = rqs_pkg::LEN_BITS_DEFAULT
) (
  input  rqs_pkg::flags_t               flags_i,
  input  logic [COUNT_BITS-1:0]         first_acc_i,
  input  logic [COUNT_BITS-1:0]         second_acc_i,
  input  logic [LEN_BITS-1:0]           length_i,
  input  logic [rqs_pkg::CH_W-1:0]      ch_i,
  input  logic                          at_end_i,
  output rqs_pkg::flags_t               flags_o,
  output logic [COUNT_BITS-1:0]         first_acc_o,
  output logic [COUNT_BITS-1:0]         second_acc_o,
  output logic [LEN_BITS-1:0]           length_o,
  output logic                          res_valid_o,
  output rqs_pkg::kind_e                kind_o,
  output logic [COUNT_BITS-1:0]         min_count_o,
  output logic [COUNT_BITS-1:0]         max_count_o,
  output logic                          max_unbounded_o,
  output logic [LEN_BITS-1:0]           consumed_o
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [LEN_BITS-1:0]   LEN_MAX   = {LEN_BITS{1'b1}};

  function automatic logic [COUNT_BITS-1:0] acc_digit(input logic [COUNT_BITS-1:0] acc,
                                                      input logic [3:0] d);
    logic [COUNT_BITS+3:0] wide;
    logic [COUNT_BITS+3:0] sum;
    wide = {4'b0000, acc};
    sum  = (wide << 3) + (wide << 1) + {{COUNT_BITS{1'b0}}, d};
    if (sum[COUNT_BITS+3:COUNT_BITS] != 4'b0000) begin
      return COUNT_MAX;
    end
    return sum[COUNT_BITS-1:0];
  endfunction

  logic       is_digit;
  logic [3:0] digit;
  logic [rqs_pkg::CH_W-1:0] digit_wide;

  assign is_digit   = (ch_i >= rqs_pkg::CH_ZERO) && (ch_i <= rqs_pkg::CH_NINE);
  assign digit_wide = ch_i - rqs_pkg::CH_ZERO;
  assign digit      = digit_wide[3:0];

  // Phase, accumulators, flags and the result word.
  always_comb begin
    flags_o.phase         = flags_i.phase;
    flags_o.comma_seen    = flags_i.comma_seen;
    flags_o.first_digits  = flags_i.first_digits;
    flags_o.second_digits = flags_i.second_digits;
    flags_o.bad_char      = flags_i.bad_char;
    first_acc_o           = first_acc_i;
    second_acc_o          = second_acc_i;
    length_o              = length_i;
    res_valid_o           = 1'b0;
    kind_o                = rqs_pkg::KIND_NONE;
    min_count_o           = '0;
    max_count_o           = '0;
    max_unbounded_o       = 1'b0;
    consumed_o            = '0;

    if (at_end_i) begin
      flags_o.phase = rqs_pkg::PH_IDLE;
      case (flags_i.phase)
        rqs_pkg::PH_IDLE: begin
          res_valid_o = 1'b1;
          kind_o      = rqs_pkg::KIND_EMPTY;
        end
        rqs_pkg::PH_BRACE: begin
          res_valid_o = 1'b1;
          kind_o      = rqs_pkg::KIND_UNMATCHED;
        end
        default: res_valid_o = 1'b0;
      endcase
    end else begin
      case (flags_i.phase)
        rqs_pkg::PH_IDLE: begin
          res_valid_o   = 1'b1;
          flags_o.phase = rqs_pkg::PH_DONE;
          case (ch_i)
            rqs_pkg::CH_QMARK: begin
              kind_o      = rqs_pkg::KIND_OPT;
              max_count_o = COUNT_BITS'(1);
              consumed_o  = LEN_BITS'(1);
            end
            rqs_pkg::CH_STAR: begin
              kind_o          = rqs_pkg::KIND_STAR;
              max_count_o     = COUNT_MAX;
              max_unbounded_o = 1'b1;
              consumed_o      = LEN_BITS'(1);
            end
            rqs_pkg::CH_PLUS: begin
              kind_o          = rqs_pkg::KIND_PLUS;
              min_count_o     = COUNT_BITS'(1);
              max_count_o     = COUNT_MAX;
              max_unbounded_o = 1'b1;
              consumed_o      = LEN_BITS'(1);
            end
            rqs_pkg::CH_LBRACE: begin
              res_valid_o           = 1'b0;
              flags_o.phase         = rqs_pkg::PH_BRACE;
              first_acc_o           = '0;
              second_acc_o          = '0;
              flags_o.comma_seen    = 2'd0;
              flags_o.first_digits  = 1'b0;
              flags_o.second_digits = 1'b0;
              flags_o.bad_char      = 1'b0;
              length_o              = LEN_BITS'(1);
            end
            default: kind_o = rqs_pkg::KIND_NONE;
          endcase
        end
        rqs_pkg::PH_BRACE: begin
          if (length_i != LEN_MAX) begin
            length_o = length_i + LEN_BITS'(1);
          end
          if (is_digit) begin
            if (flags_i.comma_seen == 2'd0) begin
              first_acc_o          = acc_digit(first_acc_i, digit);
              flags_o.first_digits = 1'b1;
            end else if (flags_i.comma_seen == 2'd1) begin
              second_acc_o          = acc_digit(second_acc_i, digit);
              flags_o.second_digits = 1'b1;
            end
          end else if (ch_i == rqs_pkg::CH_COMMA) begin
            if (flags_i.comma_seen != 2'd2) begin
              flags_o.comma_seen = flags_i.comma_seen + 2'd1;
            end
          end else if (ch_i != rqs_pkg::CH_RBRACE) begin
            flags_o.bad_char = 1'b1;
          end else begin
            res_valid_o   = 1'b1;
            flags_o.phase = rqs_pkg::PH_DONE;
            if (flags_i.bad_char) begin
              kind_o = rqs_pkg::KIND_BAD_CHAR;
            end else if (flags_i.comma_seen > 2'd1) begin
              kind_o = rqs_pkg::KIND_MANY_COMMA;
            end else if (flags_i.comma_seen == 2'd0) begin
              kind_o      = rqs_pkg::KIND_N;
              min_count_o = first_acc_i;
              max_count_o = first_acc_i;
              consumed_o  = length_o;
            end else if (!flags_i.first_digits) begin
              kind_o      = rqs_pkg::KIND_M_OR_LESS;
              max_count_o = second_acc_i;
              consumed_o  = length_o;
            end else if (!flags_i.second_digits) begin
              kind_o          = rqs_pkg::KIND_N_OR_MORE;
              min_count_o     = first_acc_i;
              max_count_o     = COUNT_MAX;
              max_unbounded_o = 1'b1;
              consumed_o      = length_o;
            end else if (first_acc_i < second_acc_i) begin
              kind_o      = rqs_pkg::KIND_N_M;
              min_count_o = first_acc_i;
              max_count_o = second_acc_i;
              consumed_o  = length_o;
            end else begin
              kind_o = rqs_pkg::KIND_BAD_RANGE;
            end
          end
        end
        rqs_pkg::PH_DONE: res_valid_o = 1'b0;
        default: begin
          res_valid_o   = 1'b0;
          flags_o.phase = rqs_pkg::PH_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/regex_quantifier_scanner.sv]
// Top level of the regex quantifier scanner: input register, scan state and result register.
//
// The text that follows a regex atom enters on the slave stream one character per word;
// a word with tlast high marks the end of the text and its tdata is ignored. The master
// stream returns at most one word per input word: tuser carries the quantifier kind and
// tdata the minimum and maximum counts, the unbounded flag and the consumed length.
// A word accepted at a clock edge is held in the input register, scanned by combinational
// logic and its result is captured in the result register that drives the master side.
// Throughput is one word per cycle while the receiver does not stall; the scan state is
// updated with a shift-and-add multiply by ten on the accumulators, and the result register
// lets a new word enter while a finished result still waits for the receiver.
// When the receiver stalls, the result register holds and the input register fills;
// tready on the slave side drops only once both are occupied.
// Reset empties both registers and returns the scanner to the start of a text.
module regex_quantifier_scanner #(
  parameter int unsigned COUNT_BITS = rqs_pkg::COUNT_BITS_DEFAULT,
  parameter int unsigned LEN_BITS   = rqs_pkg::LEN_BITS_DEFAULT,
  localparam int unsigned OUT_W       = 2 * COUNT_BITS + 1 + LEN_BITS,
  localparam int unsigned OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [rqs_pkg::CH_W-1:0]         s_axis_tdata,   // ch
  input  logic                             s_axis_tlast,   // at_end
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // min_count, max_count, max_unbounded, consumed, zero padding
  output logic [OUT_TDATA_W-1:0]           m_axis_tdata,
  output logic [rqs_pkg::KIND_W-1:0]       m_axis_tuser    // kind
);

  logic                        in_valid_q, in_valid_d;
  logic [rqs_pkg::CH_W-1:0]    in_ch_q;
  logic                        in_end_q;
  logic                        s_accept;
  logic                        advance;

  rqs_pkg::flags_t             flags_q, flags_d;
  logic [COUNT_BITS-1:0]       first_acc_q, first_acc_d;
  logic [COUNT_BITS-1:0]       second_acc_q, second_acc_d;
  logic [LEN_BITS-1:0]         length_q, length_d;

  logic                        res_valid;
  rqs_pkg::kind_e              res_kind;
  logic [COUNT_BITS-1:0]       res_min;
  logic [COUNT_BITS-1:0]       res_max;
  logic                        res_unb;
  logic [LEN_BITS-1:0]         res_cons;

  logic                        out_valid_q, out_valid_d;
  logic [rqs_pkg::KIND_W-1:0]  out_kind_q;
  logic [OUT_W-1:0]            out_data_q;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign in_valid_d  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? res_valid : (m_axis_tready ? 1'b0 : out_valid_q);

  rqs_step #(
    .COUNT_BITS (COUNT_BITS),
    .LEN_BITS   (LEN_BITS)
  ) u_step (
    .flags_i         (flags_q),
    .first_acc_i     (first_acc_q),
    .second_acc_i    (second_acc_q),
    .length_i        (length_q),
    .ch_i            (in_ch_q),
    .at_end_i        (in_end_q),
    .flags_o         (flags_d),
    .first_acc_o     (first_acc_d),
    .second_acc_o    (second_acc_d),
    .length_o        (length_d),
    .res_valid_o     (res_valid),
    .kind_o          (res_kind),
    .min_count_o     (res_min),
    .max_count_o     (res_max),
    .max_unbounded_o (res_unb),
    .consumed_o      (res_cons)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= '{phase: rqs_pkg::PH_IDLE, comma_seen: 2'd0, first_digits: 1'b0,
                       second_digits: 1'b0, bad_char: 1'b0};
      first_acc_q  <= '0;
      second_acc_q <= '0;
      length_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        flags_q      <= flags_d;
        first_acc_q  <= first_acc_d;
        second_acc_q <= second_acc_d;
        length_q     <= length_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_ch_q  <= s_axis_tdata;
      in_end_q <= s_axis_tlast;
    end
    if (advance && res_valid) begin
      out_kind_q <= res_kind;
      out_data_q <= {res_cons, res_unb, res_max, res_min};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_W){1'b0}}, out_data_q};

endmodule

[rtl/rqs_checker.sv]
// Port-level assertions for the regex quantifier scanner and their binding.
module rqs_checker #(
  parameter int unsigned COUNT_BITS = rqs_pkg::COUNT_BITS_DEFAULT,
  parameter int unsigned LEN_BITS   = rqs_pkg::LEN_BITS_DEFAULT,
  localparam int unsigned OUT_W       = 2 * COUNT_BITS + 1 + LEN_BITS,
  localparam int unsigned OUT_TDATA_W = ((OUT_W + 7) / 8) * 8,
  localparam int unsigned UNB_BIT     = 2 * COUNT_BITS
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic [rqs_pkg::CH_W-1:0]    s_axis_tdata,
  input logic                        s_axis_tlast,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  input logic [rqs_pkg::KIND_W-1:0]  m_axis_tuser
);

  logic [COUNT_BITS-1:0] max_field;
  logic                  in_used;

  assign max_field = m_axis_tdata[2*COUNT_BITS-1:COUNT_BITS];
  assign in_used   = s_axis_tvalid || (s_axis_tdata != '0) || s_axis_tlast;

  // A result that the receiver has not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  // Error kinds and the no-quantifier kinds carry an all-zero data word.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser >= rqs_pkg::KIND_UNMATCHED ||
                      m_axis_tuser == rqs_pkg::KIND_NONE ||
                      m_axis_tuser == rqs_pkg::KIND_EMPTY) |-> m_axis_tdata == '0)
    else $error("nonzero data on an error or empty kind");

  // The unbounded flag goes with an all-ones maximum and the unbounded kinds only.
  a_unbounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[UNB_BIT] |->
      (max_field == {COUNT_BITS{1'b1}}) &&
      (m_axis_tuser == rqs_pkg::KIND_STAR || m_axis_tuser == rqs_pkg::KIND_PLUS ||
       m_axis_tuser == rqs_pkg::KIND_N_OR_MORE))
    else $error("unbounded flag inconsistent with kind or maximum");

  // A result can only appear once the input side has shown tvalid, tlast or nonzero tdata at an earlier edge.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(in_used, 2) || $past(in_used, 1))
    else $error("result word without preceding input");

  // The scanner is ready when no result is offered and the past sample of s_axis_tvalid is low.
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid && !$past(s_axis_tvalid) |-> s_axis_tready)
    else $error("input stalled while the block is empty");

endmodule

bind regex_quantifier_scanner rqs_checker #(
  .COUNT_BITS (COUNT_BITS),
  .LEN_BITS   (LEN_BITS)
) u_rqs_checker (.*);
